// ----- src/touch_sample_qualify_and_map_defines.svh -----
// Assertion macros for the touch sample qualify and map block.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef TOUCH_SAMPLE_QUALIFY_AND_MAP_DEFINES_SVH
`define TOUCH_SAMPLE_QUALIFY_AND_MAP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TSQM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TSQM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tsqm_pkg.sv -----
// Shared types and constants of the touch sample qualify and map block.
// Used by tsqm_map, tsqm_div and touch_sample_qualify_and_map.
`default_nettype none

package tsqm_pkg;

  localparam int RawW     = 13;
  localparam int ExtW     = 11;
  localparam int PtW      = 10;
  localparam int TimeW    = 32;
  localparam int IgnW     = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int AvgCount = 4;
  localparam int SumW     = RawW + 2;
  localparam int ProdW    = RawW + ExtW;
  localparam int QuoW     = ExtW;
  localparam int DivSteps = QuoW;
  localparam int DivCntW  = 4;
  localparam int InDataW  = 152;
  localparam int OutDataW = 24;

  localparam logic [RawW-1:0]  RstRawLow   = 13'd150;
  localparam logic [RawW-1:0]  RstRawHigh  = 13'd4050;
  localparam logic [RawW-1:0]  RstPressMin = 13'd80;
  localparam logic [RawW-1:0]  RstCalStart = 13'd3900;
  localparam logic [RawW-1:0]  RstCalEnd   = 13'd300;
  localparam logic [ExtW-1:0]  RstWidth    = 11'd480;
  localparam logic [ExtW-1:0]  RstHeight   = 11'd320;
  localparam logic [IgnW-1:0]  RstIgnoreMs = 16'd500;
  localparam logic [PtW-1:0]   RstHeldX    = 10'd240;
  localparam logic [PtW-1:0]   RstHeldY    = 10'd160;
  localparam logic [PtW-1:0]   PtMax       = 10'd1023;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RAW_LOW   = 3'd0,
    REG_RAW_HIGH  = 3'd1,
    REG_PRESS_MIN = 3'd2,
    REG_CAL_START = 3'd3,
    REG_CAL_END   = 3'd4,
    REG_WIDTH     = 3'd5,
    REG_HEIGHT    = 3'd6,
    REG_IGNORE_MS = 3'd7
  } tsqm_reg_e;

  // Operands for one axis mapping, as magnitudes.
  typedef struct packed {
    logic [RawW-1:0] dmag;
    logic [RawW-1:0] span;
    logic [ExtW-1:0] omax;
    logic            skip;
  } tsqm_map_t;

  typedef struct packed {
    logic             start;
    logic [ProdW-1:0] dividend;
    logic [RawW-1:0]  divisor;
  } tsqm_div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [QuoW-1:0] quot;
  } tsqm_div_rsp_t;

endpackage

`default_nettype wire

// ----- src/tsqm_map.sv -----
// Calibration front end: clamps a raw average to the calibration span and
// forms the magnitudes fed to the divider. Depends on tsqm_pkg.
`default_nettype none

module tsqm_map (
  input  logic [tsqm_pkg::RawW-1:0] raw_i,
  input  logic [tsqm_pkg::RawW-1:0] cal_start_i,
  input  logic [tsqm_pkg::RawW-1:0] cal_end_i,
  input  logic [tsqm_pkg::ExtW-1:0] extent_i,
  output tsqm_pkg::tsqm_map_t       map_o
);
  import tsqm_pkg::*;

  logic            rising;
  logic [RawW-1:0] lo_val;
  logic [RawW-1:0] hi_val;
  logic [RawW-1:0] clamped;

  always_comb begin
    rising  = cal_start_i < cal_end_i;
    lo_val  = rising ? cal_start_i : cal_end_i;
    hi_val  = rising ? cal_end_i : cal_start_i;
    if (raw_i < lo_val) begin
      clamped = lo_val;
    end else if (raw_i > hi_val) begin
      clamped = hi_val;
    end else begin
      clamped = raw_i;
    end
    // Distance and span share a sign, so work on magnitudes.
    map_o.dmag = rising ? (clamped - cal_start_i) : (cal_start_i - clamped);
    map_o.span = hi_val - lo_val;
    map_o.omax = extent_i - 11'd1;
    // Empty span or zero extent both map to coordinate zero.
    map_o.skip = (map_o.span == '0) || (extent_i == '0);
  end

endmodule

`default_nettype wire

// ----- src/tsqm_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// The quotient is known to fit QuoW bits. Depends on tsqm_pkg.
`default_nettype none

module tsqm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tsqm_pkg::tsqm_div_req_t   req_i,
  output tsqm_pkg::tsqm_div_rsp_t   rsp_o
);
  import tsqm_pkg::*;

  logic [RawW-1:0]    rem_q, rem_d;
  logic [QuoW-1:0]    quo_q, quo_d;
  logic [RawW-1:0]    dsr_q, dsr_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [RawW:0]      shifted;
  logic [RawW+1:0]    trial;

  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q, quo_q[QuoW-1]};
    trial   = {1'b0, shifted} - {2'b00, dsr_q};
    if (req_i.start) begin
      // Upper bits are already below the divisor.
      rem_d  = req_i.dividend[ProdW-1:QuoW];
      quo_d  = req_i.dividend[QuoW-1:0];
      dsr_d  = req_i.divisor;
      cnt_d  = DivCntW'(DivSteps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[RawW+1]) begin
        rem_d = trial[RawW-1:0];
        quo_d = {quo_q[QuoW-2:0], 1'b1};
      end else begin
        rem_d = shifted[RawW-1:0];
        quo_d = {quo_q[QuoW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

`default_nettype wire

// ----- src/touch_sample_qualify_and_map.sv -----
// Touch scan qualification and screen mapping: averages, window checks,
// wake handling and linear calibration through one shared divider.
// Depends on tsqm_pkg, tsqm_map, tsqm_div and the assertion macro header.
//
// Each request carries one controller scan and yields exactly one result.
// The input side is ready only while the sequencer is idle. A scan that is
// rejected, wakes the screen or falls in the ignore window goes from the
// qualify state straight to the output state. For a pressed touch each axis
// goes through a clamp state, a multiply that loads the shared divider,
// 11 divider steps and the collection of the quotient, and the two axes
// use the divider one after the other. An axis whose calibration span is
// empty or whose extent is zero skips the divider and its steps. The result
// sits in an output register, so the next request is taken while it waits
// to be read.
`default_nettype none
`include "touch_sample_qualify_and_map_defines.svh"

module touch_sample_qualify_and_map (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // x_sample_a..d, y_sample_a..d, pressure_z1, pen_irq_active,
  // screen_asleep, now_ms (lowest bit first), zero filled
  input  logic [tsqm_pkg::InDataW-1:0]    s_axis_tdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // pressed, point_x, point_y, wake_request, touch_activity, zero filled
  output logic [tsqm_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_we_i,
  input  logic [tsqm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tsqm_pkg::CfgDataW-1:0]   cfg_data_i
);
  import tsqm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QUAL,
    S_CLAMP,
    S_START,
    S_DIV,
    S_OUT
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [RawW-1:0]  raw_low_q;
  logic [RawW-1:0]  raw_high_q;
  logic [RawW-1:0]  press_min_q;
  logic [RawW-1:0]  cal_start_q;
  logic [RawW-1:0]  cal_end_q;
  logic [ExtW-1:0]  width_q;
  logic [ExtW-1:0]  height_q;
  logic [IgnW-1:0]  ignore_ms_q;

  // Scan registers
  logic [RawW-1:0]  ax_q;
  logic [RawW-1:0]  ay_q;
  logic [RawW-1:0]  z1_q;
  logic             irq_q;
  logic             asleep_q;
  logic [TimeW-1:0] now_q;

  // Working and held state
  logic             axis_q;
  tsqm_map_t        map_q;
  logic [PtW-1:0]   new_x_q;
  logic [PtW-1:0]   new_y_q;
  logic             pressed_q;
  logic             wake_q;
  logic [PtW-1:0]   held_x_q;
  logic [PtW-1:0]   held_y_q;
  logic [TimeW-1:0] ign_q;

  // Output register
  logic             out_valid_q;
  logic             out_pressed_q;
  logic             out_wake_q;
  logic [PtW-1:0]   out_x_q;
  logic [PtW-1:0]   out_y_q;

  logic [RawW-1:0]  smp_x [AvgCount];
  logic [RawW-1:0]  smp_y [AvgCount];
  logic [SumW-1:0]  sum_x;
  logic [SumW-1:0]  sum_y;
  logic [RawW-1:0]  avg_x;
  logic [RawW-1:0]  avg_y;

  logic             in_acc;
  logic             out_free;
  logic             raw_ok;
  logic             press_ok;
  logic             valid;
  logic [TimeW-1:0] since_ign;
  logic [RawW-1:0]  map_raw;
  logic [ExtW-1:0]  map_ext;
  tsqm_map_t        map_c;
  logic [ProdW-1:0] product;
  logic [PtW-1:0]   coord;
  tsqm_div_req_t    div_req;
  tsqm_div_rsp_t    div_rsp;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;

  always_comb begin
    sum_x = '0;
    sum_y = '0;
    for (int i = 0; i < AvgCount; i++) begin
      smp_x[i] = s_axis_tdata[i*RawW +: RawW];
      smp_y[i] = s_axis_tdata[(i+4)*RawW +: RawW];
      sum_x    = sum_x + SumW'(smp_x[i]);
      sum_y    = sum_y + SumW'(smp_y[i]);
    end
    avg_x = RawW'(sum_x / SumW'(AvgCount));
    avg_y = RawW'(sum_y / SumW'(AvgCount));
  end

  always_comb begin
    raw_ok    = (ax_q > raw_low_q) && (ax_q < raw_high_q) &&
                (ay_q > raw_low_q) && (ay_q < raw_high_q);
    press_ok  = (z1_q > press_min_q) && (z1_q < raw_high_q);
    valid     = raw_ok && (irq_q || press_ok);
    since_ign = now_q - ign_q;
  end

  // First pass maps the Y average onto screen x, second the X average.
  assign map_raw = axis_q ? ax_q : ay_q;
  assign map_ext = axis_q ? height_q : width_q;

  tsqm_map u_map (
    .raw_i       (map_raw),
    .cal_start_i (cal_start_q),
    .cal_end_i   (cal_end_q),
    .extent_i    (map_ext),
    .map_o       (map_c)
  );

  assign product          = ProdW'(map_q.dmag) * ProdW'(map_q.omax);
  assign div_req.start    = (state_q == S_START) && !map_q.skip;
  assign div_req.dividend = product;
  assign div_req.divisor  = map_q.span;

  tsqm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Saturate the quotient to the point range; a skipped axis gives zero.
  always_comb begin
    if (state_q == S_START) begin
      coord = '0;
    end else if (div_rsp.quot[QuoW-1]) begin
      coord = PtMax;
    end else begin
      coord = div_rsp.quot[PtW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_low_q   <= RstRawLow;
      raw_high_q  <= RstRawHigh;
      press_min_q <= RstPressMin;
      cal_start_q <= RstCalStart;
      cal_end_q   <= RstCalEnd;
      width_q     <= RstWidth;
      height_q    <= RstHeight;
      ignore_ms_q <= RstIgnoreMs;
    end else if (cfg_we_i) begin
      unique case (tsqm_reg_e'(cfg_idx_i))
        REG_RAW_LOW:   raw_low_q   <= cfg_data_i[RawW-1:0];
        REG_RAW_HIGH:  raw_high_q  <= cfg_data_i[RawW-1:0];
        REG_PRESS_MIN: press_min_q <= cfg_data_i[RawW-1:0];
        REG_CAL_START: cal_start_q <= cfg_data_i[RawW-1:0];
        REG_CAL_END:   cal_end_q   <= cfg_data_i[RawW-1:0];
        REG_WIDTH:     width_q     <= cfg_data_i[ExtW-1:0];
        REG_HEIGHT:    height_q    <= cfg_data_i[ExtW-1:0];
        REG_IGNORE_MS: ignore_ms_q <= cfg_data_i[IgnW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ax_q     <= avg_x;
      ay_q     <= avg_y;
      z1_q     <= s_axis_tdata[8*RawW +: RawW];
      irq_q    <= s_axis_tdata[9*RawW];
      asleep_q <= s_axis_tdata[9*RawW+1];
      now_q    <= s_axis_tdata[9*RawW+2 +: TimeW];
    end
    if (state_q == S_CLAMP) begin
      map_q <= map_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      axis_q        <= 1'b0;
      new_x_q       <= '0;
      new_y_q       <= '0;
      pressed_q     <= 1'b0;
      wake_q        <= 1'b0;
      held_x_q      <= RstHeldX;
      held_y_q      <= RstHeldY;
      ign_q         <= '0;
      out_valid_q   <= 1'b0;
      out_pressed_q <= 1'b0;
      out_wake_q    <= 1'b0;
      out_x_q       <= '0;
      out_y_q       <= '0;
    end else begin
      // The output state loads the register itself.
      if (m_axis_tready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q) inside
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_QUAL;
          end
        end
        S_QUAL: begin
          pressed_q <= 1'b0;
          wake_q    <= 1'b0;
          axis_q    <= 1'b0;
          if (!valid) begin
            state_q <= S_OUT;
          end else if (asleep_q) begin
            // Wake the screen and open the ignore window.
            wake_q  <= 1'b1;
            ign_q   <= now_q + TimeW'(ignore_ms_q);
            state_q <= S_OUT;
          end else if (since_ign[TimeW-1]) begin
            state_q <= S_OUT;
          end else begin
            state_q <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          state_q <= S_START;
        end
        S_START, S_DIV: begin
          if ((state_q == S_START && map_q.skip) ||
              (state_q == S_DIV && div_rsp.done)) begin
            if (!axis_q) begin
              new_x_q <= coord;
              axis_q  <= 1'b1;
              state_q <= S_CLAMP;
            end else begin
              new_y_q   <= coord;
              pressed_q <= 1'b1;
              state_q   <= S_OUT;
            end
          end else if (state_q == S_START) begin
            state_q <= S_DIV;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_pressed_q <= pressed_q;
            out_wake_q    <= wake_q;
            out_x_q       <= pressed_q ? new_x_q : held_x_q;
            out_y_q       <= pressed_q ? new_y_q : held_y_q;
            if (pressed_q) begin
              held_x_q <= new_x_q;
              held_y_q <= new_y_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_pressed_q, out_wake_q, out_y_q, out_x_q,
                          out_pressed_q};

  `TSQM_ASSERT_NXT(a_busy_after_req, in_acc, !s_axis_tready, "request taken while busy")
  `TSQM_ASSERT_IMP(a_wake_released, m_axis_tvalid, !(out_wake_q && out_pressed_q),
                   "wake result reports pressed")
  `TSQM_ASSERT_IMP(a_div_owned, div_rsp.busy, state_q == S_DIV,
                   "divider runs outside the divide state")
  `TSQM_ASSERT_NXT(a_held_stable, !(state_q == S_OUT && out_free),
                   $stable(held_x_q) && $stable(held_y_q), "held point changed mid scan")

endmodule

`default_nettype wire

// ----- tb/tb_touch_sample_qualify_and_map.sv -----
// Testbench for touch_sample_qualify_and_map: directed and random touch scans, each
// result checked field by field against an in-bench model of the qualify and map rules.
// Depends on tsqm_pkg and the RTL of the block.
module tb_touch_sample_qualify_and_map;
  import tsqm_pkg::*;

  // One scan, packed so that {1'b0, scan} is the request word (x samples lowest).
  typedef struct packed {
    logic [TimeW-1:0]     now_ms;
    logic                 asleep;
    logic                 pen_irq;
    logic [RawW-1:0]      z1;
    logic [3:0][RawW-1:0] y;
    logic [3:0][RawW-1:0] x;
  } touch_scan_t;

  // One result, packed in result word order (pressed lowest).
  typedef struct packed {
    logic           activity;
    logic           wake;
    logic [PtW-1:0] py;
    logic [PtW-1:0] px;
    logic           pressed;
  } touch_report_t;

  typedef struct packed {
    logic [RawW-1:0] raw_low;
    logic [RawW-1:0] raw_high;
    logic [RawW-1:0] press_min;
    logic [RawW-1:0] cal_start;
    logic [RawW-1:0] cal_end;
    logic [ExtW-1:0] width;
    logic [ExtW-1:0] height;
    logic [IgnW-1:0] ignore_ms;
  } touch_cfg_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Model state
  touch_cfg_t       regs;
  logic [PtW-1:0]   last_px;
  logic [PtW-1:0]   last_py;
  logic [TimeW-1:0] quiet_until;
  touch_report_t    pending_reports[$];

  int               fail_count;
  int               scans_sent;
  int               reports_seen;
  int               press_seen;
  int               wake_seen;
  int               settings_used;
  bit               tx_idle_on;
  bit               rx_idle_on;
  logic [TimeW-1:0] clock_ms;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  touch_sample_qualify_and_map uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  function automatic logic [PtW-1:0] map_axis(input int raw, input int extent);
    longint lo;
    longint hi;
    longint val;
    longint span;
    longint r;
    lo   = regs.cal_start;
    hi   = regs.cal_end;
    val  = raw;
    span = hi - lo;
    if (lo < hi) begin
      if (val < lo) val = lo;
      if (val > hi) val = hi;
    end else begin
      if (val > lo) val = lo;
      if (val < hi) val = hi;
    end
    if (span == 0) return '0;
    r = ((val - lo) * (extent - 1)) / span;
    if (r < 0) r = 0;
    if (r > 1023) r = 1023;
    return r[PtW-1:0];
  endfunction

  // Compute the result of one accepted scan and advance the model state.
  function automatic touch_report_t qualify_and_map(input touch_scan_t s);
    touch_report_t    rep;
    int               sum_x;
    int               sum_y;
    int               avg_x;
    int               avg_y;
    int               i;
    logic             raw_ok;
    logic             press_ok;
    logic [TimeW-1:0] since;
    sum_x = 0;
    sum_y = 0;
    for (i = 0; i < AvgCount; i++) begin
      sum_x += s.x[i];
      sum_y += s.y[i];
    end
    avg_x    = sum_x / AvgCount;
    avg_y    = sum_y / AvgCount;
    raw_ok   = avg_x > regs.raw_low && avg_x < regs.raw_high &&
               avg_y > regs.raw_low && avg_y < regs.raw_high;
    press_ok = s.z1 > regs.press_min && s.z1 < regs.raw_high;
    rep      = '0;
    if (raw_ok && (s.pen_irq || press_ok)) begin
      if (s.asleep) begin
        rep.wake    = 1'b1;
        quiet_until = s.now_ms + regs.ignore_ms;
      end else begin
        // Top bit of the wrapped difference set means still inside the window.
        since = s.now_ms - quiet_until;
        if (!since[TimeW-1]) begin
          rep.pressed  = 1'b1;
          rep.activity = 1'b1;
          last_px      = map_axis(avg_y, regs.width);
          last_py      = map_axis(avg_x, regs.height);
        end
      end
    end
    rep.px = last_px;
    rep.py = last_py;
    return rep;
  endfunction

  function automatic touch_scan_t build_scan(input int avg_x, input int avg_y, input int spread,
                                             input int z1, input bit irq, input bit asleep,
                                             input logic [TimeW-1:0] now);
    touch_scan_t s;
    int          i;
    int          v;
    for (i = 0; i < 4; i++) begin
      v = avg_x + $urandom_range(0, 2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 8191) v = 8191;
      s.x[i] = v;
      v = avg_y + $urandom_range(0, 2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 8191) v = 8191;
      s.y[i] = v;
    end
    s.z1      = z1;
    s.pen_irq = irq;
    s.asleep  = asleep;
    s.now_ms  = now;
    return s;
  endfunction

  // A plausible touch for the current registers, with random content.
  function automatic touch_scan_t well_formed_scan();
    int lo;
    int hi;
    int ax;
    int ay;
    int z;
    lo = regs.raw_low + 1;
    hi = regs.raw_high - 1;
    if (hi < lo) begin
      lo = 0;
      hi = 8191;
    end
    ax = $urandom_range(lo, hi);
    ay = $urandom_range(lo, hi);
    if ($urandom_range(0, 7) == 0) ax = $urandom_range(0, 1) ? lo : hi;
    if ($urandom_range(0, 7) == 0) ay = $urandom_range(0, 1) ? lo : hi;
    lo = regs.press_min + 1;
    hi = regs.raw_high - 1;
    if (hi < lo) begin
      lo = 0;
      hi = 8191;
    end
    z = ($urandom_range(0, 4) != 0) ? $urandom_range(lo, hi) : $urandom_range(0, 8191);
    return build_scan(ax, ay, $urandom_range(0, 4), z, $urandom_range(0, 1),
                      $urandom_range(0, 11) == 0, clock_ms);
  endfunction

  function automatic touch_scan_t noise_scan();
    touch_scan_t s;
    int          i;
    if ($urandom_range(0, 1)) begin
      // Broken touch: one sample pinned to a rail.
      s = well_formed_scan();
      i = $urandom_range(0, 3);
      if ($urandom_range(0, 1)) s.x[i] = $urandom_range(0, 1) ? '1 : '0;
      else s.y[i] = $urandom_range(0, 1) ? '1 : '0;
    end else begin
      for (i = 0; i < 4; i++) begin
        s.x[i] = $urandom_range(0, 8191);
        s.y[i] = $urandom_range(0, 8191);
      end
      s.z1      = $urandom_range(0, 8191);
      s.pen_irq = $urandom_range(0, 1);
      s.asleep  = $urandom_range(0, 1);
      s.now_ms  = $urandom_range(0, 1) ? $urandom : clock_ms;
    end
    return s;
  endfunction

  function automatic touch_cfg_t default_setting();
    touch_cfg_t c;
    c.raw_low   = RstRawLow;
    c.raw_high  = RstRawHigh;
    c.press_min = RstPressMin;
    c.cal_start = RstCalStart;
    c.cal_end   = RstCalEnd;
    c.width     = RstWidth;
    c.height    = RstHeight;
    c.ignore_ms = RstIgnoreMs;
    return c;
  endfunction

  function automatic touch_cfg_t random_setting(input bit wild);
    touch_cfg_t c;
    if (wild) begin
      c.raw_low   = $urandom_range(0, 8191);
      c.raw_high  = $urandom_range(0, 8191);
      c.press_min = $urandom_range(0, 8191);
      c.width     = $urandom_range(0, 2047);
      c.height    = $urandom_range(0, 2047);
      c.ignore_ms = $urandom_range(0, 65535);
    end else begin
      c.raw_low   = $urandom_range(0, 600);
      c.raw_high  = $urandom_range(3000, 8191);
      c.press_min = $urandom_range(0, 400);
      c.width     = $urandom_range(1, 1024);
      c.height    = $urandom_range(1, 1024);
      c.ignore_ms = $urandom_range(0, 3000);
      if ($urandom_range(0, 7) == 0) c.width = $urandom_range(0, 1) ? 0 : 2047;
      if ($urandom_range(0, 7) == 0) c.ignore_ms = $urandom_range(0, 1) ? 0 : 65535;
    end
    c.cal_start = $urandom_range(0, 8191);
    c.cal_end   = ($urandom_range(0, 7) == 0) ? c.cal_start : $urandom_range(0, 8191);
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic send_scan(input touch_scan_t s);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, s};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_reports.push_back(qualify_and_map(s));
    scans_sent++;
  endtask

  // Hold off requests until every pending result is back, then wait extra cycles.
  task automatic settle(input int extra);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_reports.size() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(input tsqm_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input touch_cfg_t c);
    settle(40);
    write_reg(REG_RAW_LOW, c.raw_low);
    write_reg(REG_RAW_HIGH, c.raw_high);
    write_reg(REG_PRESS_MIN, c.press_min);
    write_reg(REG_CAL_START, c.cal_start);
    write_reg(REG_CAL_END, c.cal_end);
    write_reg(REG_WIDTH, c.width);
    write_reg(REG_HEIGHT, c.height);
    write_reg(REG_IGNORE_MS, c.ignore_ms);
    cfg_we_i <= 1'b0;
    regs = c;
    settings_used++;
  endtask

  // Reset registers: window edges, both qualify paths, clamps, wake and ignore window.
  task automatic test_default_boundaries();
    touch_scan_t s;
    send_scan(build_scan(0, 0, 0, 0, 0, 0, 32'd0));
    send_scan(build_scan(8191, 8191, 0, 8191, 1, 1, 32'hFFFF_FFFF));
    send_scan(build_scan(2000, 2000, 3, 0, 1, 0, 32'd1000));
    send_scan(build_scan(1800, 2500, 0, 81, 0, 0, 32'd1001));
    send_scan(build_scan(1800, 2500, 0, 80, 0, 0, 32'd1002));
    send_scan(build_scan(1800, 2500, 0, 4050, 0, 0, 32'd1003));
    send_scan(build_scan(1700, 2600, 0, 4049, 0, 0, 32'd1004));
    // X average truncates to exactly the low edge
    s = build_scan(150, 2000, 0, 0, 1, 0, 32'd1005);
    s.x[2] = 151;
    s.x[3] = 151;
    send_scan(s);
    // X average truncates to one below the high edge
    s = build_scan(4049, 2000, 0, 0, 1, 0, 32'd1006);
    s.x[2] = 4050;
    s.x[3] = 4050;
    send_scan(s);
    send_scan(build_scan(2000, 4050, 0, 0, 1, 0, 32'd1007));
    send_scan(build_scan(200, 4000, 0, 0, 1, 0, 32'd1008));
    send_scan(build_scan(1000, 1000, 2, 0, 1, 1, 32'd10000));
    send_scan(build_scan(10, 10, 0, 0, 1, 1, 32'd10100));
    send_scan(build_scan(3000, 900, 0, 0, 1, 0, 32'd10499));
    send_scan(build_scan(3000, 900, 0, 0, 1, 0, 32'd10500));
    // Wake window that wraps past zero
    send_scan(build_scan(2500, 2500, 0, 0, 1, 1, 32'hFFFF_FF00));
    send_scan(build_scan(2600, 2400, 0, 0, 1, 0, 32'h0000_0010));
    send_scan(build_scan(2600, 2400, 0, 0, 1, 0, 32'h0000_00F4));
  endtask

  // Register extremes: open window, reversed span, odd extents, empty span.
  task automatic test_register_extremes();
    touch_cfg_t c;
    c = '{raw_low: 0, raw_high: 8191, press_min: 0, cal_start: 0, cal_end: 8191,
          width: 1024, height: 1024, ignore_ms: 0};
    apply_setting(c);
    send_scan(build_scan(1, 8190, 0, 1, 0, 0, 32'h0000_1000));
    send_scan(build_scan(4000, 4000, 0, 1, 0, 1, 32'h0000_2000));
    send_scan(build_scan(8000, 5, 0, 1, 0, 0, 32'h0000_2000));
    c = '{raw_low: 0, raw_high: 8191, press_min: 8191, cal_start: 8191, cal_end: 0,
          width: 0, height: 2047, ignore_ms: 65535};
    apply_setting(c);
    send_scan(build_scan(100, 5000, 0, 0, 1, 0, 32'h0000_3000));
    send_scan(build_scan(100, 5000, 0, 8190, 0, 0, 32'h0000_3001));
    c = default_setting();
    c.cal_start = 2000;
    c.cal_end   = 2000;
    apply_setting(c);
    send_scan(build_scan(1000, 3000, 1, 0, 1, 0, 32'h0000_4000));
  endtask

  // Mostly plausible touch sessions with random content, the rest noise.
  task automatic test_random_sessions();
    int phase;
    int n;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: apply_setting(default_setting());
        3: apply_setting(random_setting(1'b1));
        default: apply_setting(random_setting(1'b0));
      endcase
      clock_ms = (phase == 2) ? 32'hFFFF_C000 : $urandom;
      for (n = 0; n < 150; n++) begin
        if (n % 50 == 0) begin
          tx_idle_on = $urandom_range(0, 3) != 0;
          rx_idle_on = $urandom_range(0, 3) != 0;
        end
        if (n == 75) settle(0);
        clock_ms = clock_ms + $urandom_range(1, 300);
        if ($urandom_range(0, 19) == 0) clock_ms = clock_ms + $urandom_range(0, 200000);
        if ($urandom_range(0, 9) < 7) send_scan(well_formed_scan());
        else send_scan(noise_scan());
      end
    end
  endtask

  initial begin : result_checker
    touch_report_t got;
    touch_report_t want;
    int            stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      got = m_axis_tdata[$bits(touch_report_t)-1:0];
      reports_seen++;
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing pending: %h", reports_seen, got));
      end else begin
        want = pending_reports.pop_front();
        if (want.pressed) press_seen++;
        if (want.wake) wake_seen++;
        if (got.pressed !== want.pressed)
          report_mismatch($sformatf("result %0d pressed %b, want %b",
                                    reports_seen, got.pressed, want.pressed));
        if (got.px !== want.px)
          report_mismatch($sformatf("result %0d point_x %0d, want %0d",
                                    reports_seen, got.px, want.px));
        if (got.py !== want.py)
          report_mismatch($sformatf("result %0d point_y %0d, want %0d",
                                    reports_seen, got.py, want.py));
        if (got.wake !== want.wake)
          report_mismatch($sformatf("result %0d wake_request %b, want %b",
                                    reports_seen, got.wake, want.wake));
        if (got.activity !== want.activity)
          report_mismatch($sformatf("result %0d touch_activity %b, want %b",
                                    reports_seen, got.activity, want.activity));
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("timeout with %0d results still pending", pending_reports.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : run
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_RAW_LOW;
    cfg_data_i    <= '0;
    rst_ni        <= 1'b0;
    regs          = default_setting();
    last_px       = RstHeldX;
    last_py       = RstHeldY;
    quiet_until   = '0;
    fail_count    = 0;
    scans_sent    = 0;
    reports_seen  = 0;
    press_seen    = 0;
    wake_seen     = 0;
    settings_used = 1;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    clock_ms      = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_boundaries();
    test_register_extremes();
    test_random_sessions();
    settle(40);

    $display("covered %0d scans under %0d register settings", scans_sent, settings_used);
    $display("checked %0d results: %0d pressed, %0d wake requests, %0d mismatches",
             reports_seen, press_seen, wake_seen, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
